>>> rtl/mf3_pkg.sv
// Shared types and constants of the 3x3 max filter.
`timescale 1ns / 1ps

package mf3_pkg;

  // Configuration register map
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 11;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_COLUMNS = 1'b0,
    CFG_ROWS    = 1'b1
  } cfg_index_e;

  // Column maxima held behind the current column of the window
  localparam int HIST_CELLS = 2;

  // Smallest frame edge the filter handles
  localparam int MIN_EDGE = 3;

endpackage

>>> rtl/mf3_line_store.sv
// One line store: single write port, single registered read port.
`timescale 1ns / 1ps

module mf3_line_store #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/mf3_cell.sv
// Window cell: holds one column maximum and folds it into the running maximum.
`timescale 1ns / 1ps

module mf3_cell #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             shift_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic [WIDTH-1:0] max_i,
  output logic [WIDTH-1:0] data_o,
  output logic [WIDTH-1:0] max_o
);

  logic [WIDTH-1:0] data_q;

  // Take the neighbour's column maximum on every advance
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= data_i;
    end
  end

  assign data_o = data_q;
  assign max_o  = (data_q > max_i) ? data_q : max_i;

endmodule

>>> rtl/max_filter_3x3.sv
// Throughput: one pixel per clock while the output is not stalled, set by the one read
// and one write port per line store. Beats go through stage one, then the output register.
// A stalled output holds one result while the next pixel is still taken into stage one.
// Reset: position counters to zero, cfg_cols_q and cfg_rows_q to 1024.
// Line stores are not cleared: rows 0 and 1 of a frame fill them and emit no results.
`timescale 1ns / 1ps

module max_filter_3x3 #(
  parameter int MAX_COLUMNS = 1024,
  parameter int PIXEL_BITS  = 8,
  parameter int MAX_ROWS    = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // pixel input
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [PIXEL_BITS-1:0]              pixel_value_i,
  // result output
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [PIXEL_BITS-1:0]              window_max_o,
  output logic                               row_end_o,
  output logic                               frame_end_o,
  // configuration writes
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [mf3_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [mf3_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int NC = mf3_pkg::HIST_CELLS;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pix;
    logic [CW-1:0]         idx;
    logic                  emit;
    logic                  row_end;
    logic                  frame_end;
  } stage_t;

  logic [mf3_pkg::CFG_DATA_W-1:0] cfg_cols_q, cfg_rows_q;
  logic [CW-1:0]         col_q, col_d;
  logic [RW-1:0]         row_q, row_d;
  logic                  s1_valid_q, s1_valid_d;
  stage_t                s1_q, s1_d;
  logic                  out_valid_q, out_valid_d;
  logic [PIXEL_BITS-1:0] window_max_q, window_max_d;
  logic                  row_end_q, row_end_d;
  logic                  frame_end_q, frame_end_d;

  logic [31:0]           cols_eff, rows_eff;
  logic                  last_col, last_row;
  logic                  in_accept, adv1;
  logic [PIXEL_BITS-1:0] up2, up1, colmax;
  logic [PIXEL_BITS-1:0] hist [NC];
  logic [PIXEL_BITS-1:0] chain_max [NC];

  // Configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_cols_q <= mf3_pkg::CFG_DATA_W'(1024);
      cfg_rows_q <= mf3_pkg::CFG_DATA_W'(1024);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        mf3_pkg::CFG_COLUMNS: cfg_cols_q <= cfg_data_i;
        mf3_pkg::CFG_ROWS:    cfg_rows_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Frame geometry clamped to the supported range
  always_comb begin
    cols_eff = 32'(cfg_cols_q);
    if (cols_eff < 32'(mf3_pkg::MIN_EDGE)) cols_eff = 32'(mf3_pkg::MIN_EDGE);
    else if (cols_eff > 32'(MAX_COLUMNS)) cols_eff = 32'(MAX_COLUMNS);
    rows_eff = 32'(cfg_rows_q);
    if (rows_eff < 32'(mf3_pkg::MIN_EDGE)) rows_eff = 32'(mf3_pkg::MIN_EDGE);
    else if (rows_eff > 32'(MAX_ROWS)) rows_eff = 32'(MAX_ROWS);
  end

  assign last_col = (32'(col_q) + 32'd1) >= cols_eff;
  assign last_row = (32'(row_q) + 32'd1) >= rows_eff;

  // Handshake: stage one moves on when the output register is free or being taken
  assign adv1       = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !adv1;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Line stores: read at accept, write back as the beat leaves stage one
  mf3_line_store #(.DEPTH(MAX_COLUMNS), .WIDTH(PIXEL_BITS)) u_older (
    .clk_i     (clk_i),
    .rd_en_i   (in_accept),
    .rd_addr_i (col_q),
    .rd_data_o (up2),
    .wr_en_i   (adv1),
    .wr_addr_i (s1_q.idx),
    .wr_data_i (up1)
  );

  mf3_line_store #(.DEPTH(MAX_COLUMNS), .WIDTH(PIXEL_BITS)) u_newer (
    .clk_i     (clk_i),
    .rd_en_i   (in_accept),
    .rd_addr_i (col_q),
    .rd_data_o (up1),
    .wr_en_i   (adv1),
    .wr_addr_i (s1_q.idx),
    .wr_data_i (s1_q.pix)
  );

  // Column maximum of the current column
  always_comb begin
    colmax = (up2 > up1) ? up2 : up1;
    if (s1_q.pix > colmax) colmax = s1_q.pix;
  end

  // Chain of window cells holding the previous column maxima
  for (genvar k = 0; k < NC; k++) begin : g_cell
    if (k == 0) begin : g_first
      mf3_cell #(.WIDTH(PIXEL_BITS)) u_cell (
        .clk_i   (clk_i),
        .shift_i (adv1),
        .data_i  (colmax),
        .max_i   (colmax),
        .data_o  (hist[k]),
        .max_o   (chain_max[k])
      );
    end else begin : g_next
      mf3_cell #(.WIDTH(PIXEL_BITS)) u_cell (
        .clk_i   (clk_i),
        .shift_i (adv1),
        .data_i  (hist[k-1]),
        .max_i   (chain_max[k-1]),
        .data_o  (hist[k]),
        .max_o   (chain_max[k])
      );
    end
  end

  // Next-state logic for counters, stage one and the output register
  always_comb begin
    col_d        = col_q;
    row_d        = row_q;
    s1_valid_d   = s1_valid_q;
    s1_d         = s1_q;
    out_valid_d  = out_valid_q;
    window_max_d = window_max_q;
    row_end_d    = row_end_q;
    frame_end_d  = frame_end_q;

    if (adv1) begin
      s1_valid_d   = 1'b0;
      out_valid_d  = s1_q.emit;
      window_max_d = chain_max[NC-1];
      row_end_d    = s1_q.row_end;
      frame_end_d  = s1_q.frame_end;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (in_accept) begin
      s1_valid_d     = 1'b1;
      s1_d.pix       = pixel_value_i;
      s1_d.idx       = col_q;
      s1_d.emit      = (32'(row_q) >= 32'd2) && (32'(col_q) >= 32'd2);
      s1_d.row_end   = last_col;
      s1_d.frame_end = last_col && last_row;
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : RW'(32'(row_q) + 32'd1);
      end else begin
        col_d = CW'(32'(col_q) + 32'd1);
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    s1_q         <= s1_d;
    window_max_q <= window_max_d;
    row_end_q    <= row_end_d;
    frame_end_q  <= frame_end_d;
  end

  assign out_valid_o  = out_valid_q;
  assign window_max_o = window_max_q;
  assign row_end_o    = row_end_q;
  assign frame_end_o  = frame_end_q;

endmodule

>>> rtl/mf3_checker.sv
// Port-level assertions for the 3x3 max filter, bound to the top level.
`timescale 1ns / 1ps

module mf3_checker #(
  parameter int PIXEL_BITS = 8
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [PIXEL_BITS-1:0] window_max_o,
  input logic                  row_end_o,
  input logic                  frame_end_o
);

  // A stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(window_max_o) && $stable(row_end_o) && $stable(frame_end_o))
    else $error("result payload changed while stalled");

  // The end of a frame is always the end of a row
  a_frame_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> row_end_o)
    else $error("frame end without row end");

  // The input only backs up behind a waiting, stalled result
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with the output free");

endmodule

bind max_filter_3x3 mf3_checker #(.PIXEL_BITS(PIXEL_BITS)) u_mf3_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .window_max_o (window_max_o),
  .row_end_o    (row_end_o),
  .frame_end_o  (frame_end_o)
);
